/* hdl/vspd_pkg.sv */
// Shared types and constants for the video sync pulse detector.
package vspd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int H_FIELD_W  = 18;
    localparam int V_FIELD_W  = 23;
    localparam int CNT_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic signed [SAMPLE_W-1:0]  t_sample;
    typedef logic signed [H_FIELD_W-1:0] t_h_thr;
    typedef logic signed [V_FIELD_W-1:0] t_v_thr;

    // register select is byte address bit 2
    localparam logic REG_H_THR = 1'b0;
    localparam logic REG_V_THR = 1'b1;

    localparam t_h_thr H_THR_RESET = -18'sd1946;
    localparam t_v_thr V_THR_RESET = -23'sd55808;

endpackage

/* hdl/video_sync_pulse_detector.sv */
// Top level of the boxcar video sync pulse detector.
//
// One signed Q2.10 sample is taken per transfer and every sample gives one result
// transfer. The block sustains one sample per clock while the output side keeps
// taking results. A sample passes three registered stages in order: the sample
// register and delay-line reads, the difference stage, then the accumulators and
// the result register, which presents it. The three stages stall together
// only as far as the output side holds back. The history is held as separate
// delay lines, one per tap except the newest vertical tap, which is the sample
// register. Each is a small circular RAM with one write and one registered read
// per sample. A line reads zero until it has seen as many samples as its
// length, so start-up needs no clearing pass. Horizontal sync: a running sum over
// the last H_WINDOW samples, flagged when below h_threshold. Vertical sync: a
// running sum of V_TAPS windows of V_WINDOW samples ending at the current sample
// and at whole half lines before it, flagged when below v_threshold. Start
// positions are the sample count less H_WINDOW or less V_TAPS half lines, modulo
// 2^32. Thresholds sit at byte 0 and byte 4 of the APB-style port; write them
// only while the block is idle.
module video_sync_pulse_detector
    import vspd_pkg::*;
#(
    parameter int H_WINDOW    = 38,
    parameter int V_WINDOW    = 218,
    parameter int LINE_LENGTH = 512,
    parameter int V_TAPS      = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  t_sample                     i_sample,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_h_sync,
    output logic [CNT_W-1:0]            o_h_start,
    output logic signed [H_FIELD_W-1:0] o_h_strength,
    output logic                        o_v_sync,
    output logic [CNT_W-1:0]            o_v_start,
    output logic signed [V_FIELD_W-1:0] o_v_strength,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int HALF_LINE = LINE_LENGTH / 2;
    // accumulators wide enough for a full window of extreme samples
    localparam int H_NEED  = $clog2(H_WINDOW) + SAMPLE_W;
    localparam int V_NEED  = $clog2(V_TAPS * V_WINDOW) + SAMPLE_W;
    localparam int HACC_W  = (H_NEED > H_FIELD_W) ? H_NEED : H_FIELD_W;
    localparam int VACC_W  = (V_NEED > V_FIELD_W) ? V_NEED : V_FIELD_W;
    localparam int DH_W    = SAMPLE_W + 1;
    localparam int DV_W    = SAMPLE_W + 1 + $clog2(V_TAPS + 1);
    localparam logic [CNT_W-1:0] H_OFS = CNT_W'(H_WINDOW);
    localparam logic [CNT_W-1:0] V_OFS = CNT_W'(V_TAPS * HALF_LINE);

    // ---------------- register port ----------------
    t_h_thr r_h_thr;
    t_v_thr r_v_thr;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_thr <= H_THR_RESET;
            r_v_thr <= V_THR_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_H_THR: r_h_thr <= pwdata[H_FIELD_W-1:0];
                REG_V_THR: r_v_thr <= pwdata[V_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_H_THR: prdata = APB_DATA_W'(r_h_thr);
            REG_V_THR: prdata = APB_DATA_W'(r_v_thr);
            default:   prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // stage 1: sample and delay-line taps, stage 2: sum differences,
    // stage 3: accumulators and result register
    logic r_v1, r_v2, r_v3;
    logic ready3, adv3, ready2, adv2, accept;

    assign ready3     = !r_v3 || i_out_ready;
    assign adv3       = r_v2 && ready3;
    assign ready2     = !r_v2 || adv3;
    assign adv2       = r_v1 && ready2;
    assign o_in_ready = !r_v1 || adv2;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ---------------- stage 1: history taps ----------------
    t_sample r_x;
    t_sample h_tap;
    t_sample pos_tap [V_TAPS];
    t_sample neg_tap [V_TAPS];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample;
        end
    end

    vspd_delay #(.DELAY(H_WINDOW)) u_h_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept),
        .i_din   (i_sample),
        .o_dout  (h_tap)
    );

    // leading edge of the newest vertical window is the sample itself
    assign pos_tap[0] = r_x;

    for (genvar n = 1; n < V_TAPS; n++) begin : g_pos
        vspd_delay #(.DELAY(n * HALF_LINE)) u_pos_delay (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_din   (i_sample),
            .o_dout  (pos_tap[n])
        );
    end

    for (genvar n = 0; n < V_TAPS; n++) begin : g_neg
        vspd_delay #(.DELAY(n * HALF_LINE + V_WINDOW)) u_neg_delay (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_din   (i_sample),
            .o_dout  (neg_tap[n])
        );
    end

    // ---------------- stage 2: per-sample change of each sum ----------------
    logic signed [DH_W-1:0] r_dh, n_dh;
    logic signed [DV_W-1:0] r_dv, n_dv;

    always_comb begin
        n_dh = DH_W'(r_x) - DH_W'(h_tap);
        n_dv = '0;
        for (int n = 0; n < V_TAPS; n++) begin
            n_dv = n_dv + DV_W'(pos_tap[n]) - DV_W'(neg_tap[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_dh <= n_dh;
            r_dv <= n_dv;
        end
    end

    // ---------------- stage 3: accumulate, compare, result register ----------------
    logic signed [HACC_W-1:0] r_hsum, n_hsum;
    logic signed [VACC_W-1:0] r_vsum, n_vsum;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_h_start, r_v_start;
    logic                     r_h_sync, r_v_sync;

    assign n_hsum = r_hsum + HACC_W'(r_dh);
    assign n_vsum = r_vsum + VACC_W'(r_dv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum <= '0;
            r_vsum <= '0;
            r_cnt  <= '0;
        end else if (adv3) begin
            r_hsum <= n_hsum;
            r_vsum <= n_vsum;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_h_sync  <= n_hsum < HACC_W'(r_h_thr);
            r_v_sync  <= n_vsum < VACC_W'(r_v_thr);
            r_h_start <= r_cnt - H_OFS;
            r_v_start <= r_cnt - V_OFS;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_h_sync     = r_h_sync;
    assign o_h_start    = r_h_start;
    assign o_h_strength = $signed(r_hsum[H_FIELD_W-1:0]);
    assign o_v_sync     = r_v_sync;
    assign o_v_start    = r_v_start;
    assign o_v_strength = $signed(r_vsum[V_FIELD_W-1:0]);

`ifndef SYNTHESIS
    // input side only backs up when every stage is full and the output is held
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    // a transfer out of stage 2 always lands a result
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv3 |=> o_out_valid)
        else $error("stage 2 transfer lost");

    // both start positions come from the same count
    a_start_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_h_start - o_v_start) == (V_OFS - H_OFS)))
        else $error("start positions out of step");

    // the sums hold while a result is held at the output
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_hsum) && $stable(r_vsum)))
        else $error("sum changed while result held");
`endif

endmodule

/* hdl/vspd_delay.sv */
// Fixed-length sample delay line on a circular RAM, reads zero until first filled.
module vspd_delay
    import vspd_pkg::*;
#(
    parameter int DELAY = 38
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_sample i_din,
    output t_sample o_dout
);

    localparam int PTR_W = (DELAY > 1) ? $clog2(DELAY) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DELAY - 1);

    t_sample          r_mem [DELAY];
    t_sample          r_dout;
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;
    logic             r_full;

    assign n_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
        end else if (i_shift) begin
            r_ptr <= n_ptr;
            if (r_ptr == LAST) begin
                r_full <= 1'b1;
            end
        end
    end

    // read-first: oldest entry leaves as the new one lands
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_mem[r_ptr] <= i_din;
            r_dout       <= r_full ? r_mem[r_ptr] : '0;
        end
    end

    assign o_dout = r_dout;

endmodule

/* verif/video_sync_pulse_detector_test.sv */
// Self-checking testbench for the boxcar video sync pulse detector.
`timescale 1ns / 100ps

module video_sync_pulse_detector_test
    import vspd_pkg::*;
();

    typedef struct {
        logic                        h_sync;
        logic [CNT_W-1:0]            h_start;
        logic signed [H_FIELD_W-1:0] h_strength;
        logic                        v_sync;
        logic [CNT_W-1:0]            v_start;
        logic signed [V_FIELD_W-1:0] v_strength;
    } t_sync_result;

    // Running-sum predictor plus the queue of results still owed by the block.
    class sync_sum_tracker;
        localparam int HIST_DEPTH = 2048;
        localparam int H_WINDOW   = 38;
        localparam int V_WINDOW   = 218;
        localparam int HALF_LINE  = 256;
        localparam int V_TAPS     = 5;

        t_sample          history [HIST_DEPTH];
        int               h_sum;
        int               v_sum;
        logic [CNT_W-1:0] count;
        int               wr_ptr;
        int               h_thr;
        int               v_thr;
        t_sync_result     awaited [$];
        int               faults;
        int               h_flags;
        int               v_flags;

        function new();
            foreach (history[i]) history[i] = '0;
            h_sum   = 0;
            v_sum   = 0;
            count   = '0;
            wr_ptr  = 0;
            h_thr   = H_THR_RESET;
            v_thr   = V_THR_RESET;
            faults  = 0;
            h_flags = 0;
            v_flags = 0;
        endfunction

        // only the low register-width bits count, taken as two's complement
        function void load_threshold(logic sel, logic [APB_DATA_W-1:0] word);
            t_h_thr ht;
            t_v_thr vt;
            if (sel == REG_H_THR) begin
                ht    = word[H_FIELD_W-1:0];
                h_thr = ht;
            end else begin
                vt    = word[V_FIELD_W-1:0];
                v_thr = vt;
            end
        endfunction

        function int past(int back);
            return history[(wr_ptr + HIST_DEPTH - back % HIST_DEPTH) % HIST_DEPTH];
        endfunction

        function void take_sample(t_sample x);
            t_sync_result r;
            int           lag;
            history[wr_ptr] = x;
            h_sum += int'(x) - past(H_WINDOW);
            for (int n = 0; n < V_TAPS; n++) begin
                lag    = n * HALF_LINE;
                v_sum += past(lag) - past(lag + V_WINDOW);
            end
            r.h_sync     = (h_sum < h_thr);
            r.h_start    = count - H_WINDOW;
            r.h_strength = h_sum[H_FIELD_W-1:0];
            r.v_sync     = (v_sum < v_thr);
            r.v_start    = count - V_TAPS * HALF_LINE;
            r.v_strength = v_sum[V_FIELD_W-1:0];
            h_flags += r.h_sync;
            v_flags += r.v_sync;
            awaited.push_back(r);
            count++;
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        endfunction

        function void flag(string what, logic signed [63:0] want, logic signed [63:0] got);
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void match_result(t_sync_result got);
            t_sync_result want;
            if (awaited.size() == 0) begin
                flag("result with no sample outstanding", 0, 1);
                return;
            end
            want = awaited.pop_front();
            if (got.h_sync !== want.h_sync)
                flag("h_sync", want.h_sync, got.h_sync);
            if (got.h_start !== want.h_start)
                flag("h_start", want.h_start, got.h_start);
            if (got.h_strength !== want.h_strength)
                flag("h_strength", want.h_strength, got.h_strength);
            if (got.v_sync !== want.v_sync)
                flag("v_sync", want.v_sync, got.v_sync);
            if (got.v_start !== want.v_start)
                flag("v_start", want.v_start, got.v_start);
            if (got.v_strength !== want.v_strength)
                flag("v_strength", want.v_strength, got.v_strength);
        endfunction
    endclass

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTINGS_COUNT = 6;
    localparam int SAMPLES_PER_SETTING = 138;

    // kinds of stretch the random source strings together, loosely like a video line
    typedef enum {SEG_HSYNC, SEG_BLANK, SEG_VIDEO, SEG_VSYNC, SEG_NOISE} t_segment;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    t_sample                     i_sample;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_h_sync;
    logic [CNT_W-1:0]            o_h_start;
    logic signed [H_FIELD_W-1:0] o_h_strength;
    logic                        o_v_sync;
    logic [CNT_W-1:0]            o_v_start;
    logic signed [V_FIELD_W-1:0] o_v_strength;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    sync_sum_tracker tracker;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              cycles;
    t_segment        seg_kind;
    int              seg_left;

    video_sync_pulse_detector dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_h_sync     (o_h_sync),
        .o_h_start    (o_h_start),
        .o_h_strength (o_h_strength),
        .o_v_sync     (o_v_sync),
        .o_v_start    (o_v_start),
        .o_v_strength (o_v_strength),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped by watchdog after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Everything is sampled at the rising edge; inputs only move at the falling
    // edge, so a sample transfer and a result transfer at the same edge are seen
    // consistently. The sample is predicted before the result is matched.
    always @(posedge i_clk) begin : monitor
        t_sync_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.take_sample(i_sample);
            if (o_out_valid && i_out_ready) begin
                got.h_sync     = o_h_sync;
                got.h_start    = o_h_start;
                got.h_strength = o_h_strength;
                got.v_sync     = o_v_sync;
                got.v_start    = o_v_start;
                got.v_strength = o_v_strength;
                tracker.match_result(got);
            end
        end
    end

    // Random source: sync tips, blanking and picture content in stretches of
    // random length, with bursts of full-range noise mixed in. Long sync
    // stretches are what pull the vertical sum under its threshold.
    function automatic t_sample next_video_sample();
        int pick;
        int v;
        if (seg_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                seg_kind = SEG_HSYNC;
                seg_left = $urandom_range(30, 50);
            end else if (pick < 45) begin
                seg_kind = SEG_BLANK;
                seg_left = $urandom_range(10, 40);
            end else if (pick < 75) begin
                seg_kind = SEG_VIDEO;
                seg_left = $urandom_range(100, 400);
            end else if (pick < 85) begin
                seg_kind = SEG_VSYNC;
                seg_left = $urandom_range(200, 320);
            end else begin
                seg_kind = SEG_NOISE;
                seg_left = $urandom_range(1, 30);
            end
        end
        seg_left--;
        case (seg_kind)
            SEG_HSYNC, SEG_VSYNC: v = int'($urandom_range(0, 400)) - 1300;
            SEG_BLANK:            v = int'($urandom_range(0, 80)) - 40;
            SEG_VIDEO:            v = int'($urandom_range(0, 2047));
            default:              v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        return t_sample'(v);
    endfunction

    // Entered and left at a falling edge. Valid stays high straight into the
    // next sample unless an idle cycle is drawn.
    task automatic send_sample(input t_sample x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample   = x;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Hold the sample side off until every owed result has come out.
    task automatic drain();
        i_in_valid = 1'b0;
        while (tracker.awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [APB_DATA_W-1:0] word);
        paddr   = {sel, 2'b00};
        pwdata  = word;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic sel, output logic [APB_DATA_W-1:0] word);
        paddr   = {sel, 2'b00};
        pwrite  = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        word = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        int                    h_set [SETTINGS_COUNT];
        int                    v_set [SETTINGS_COUNT];
        t_sample               corner [9];
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] back;
        int                    sent;

        // every input known from time zero
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cycles      = 0;
        seg_left    = 0;
        seg_kind    = SEG_BLANK;
        sent        = 0;
        tracker     = new();

        // Threshold settings: reset values, the register-width extremes (flag
        // stuck on or off), the extremes of the working range, zero, and a
        // random setting near where real sync levels sit.
        h_set[0] = H_THR_RESET;  v_set[0] = V_THR_RESET;
        h_set[1] = 131071;       v_set[1] = -4194304;
        h_set[2] = -77824;       v_set[2] = 2232320;
        h_set[3] = 0;            v_set[3] = 0;
        h_set[4] = -131072;      v_set[4] = 4194303;
        h_set[5] = int'($urandom_range(0, 50000)) - 40000;
        v_set[5] = int'($urandom_range(0, 700000)) - 600000;

        // sample extremes, single-bit neighbours of zero, unity, alternating bits
        corner = '{-12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd1,
                   12'sd1024, -12'sd1024, 12'sh555, 12'shAAA};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            // idling plan: sender light / receiver heavy, then swapped, then none
            case (s / 2)
                0:       begin send_idle_pct = 7;  recv_idle_pct = 56; end
                1:       begin send_idle_pct = 56; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            // The block is drained here. Upper bus bits are random: only the
            // register width is meant to take effect.
            word = $urandom();
            word[H_FIELD_W-1:0] = h_set[s][H_FIELD_W-1:0];
            apb_write(REG_H_THR, word);
            tracker.load_threshold(REG_H_THR, word);
            apb_read(REG_H_THR, back);
            if (back[H_FIELD_W-1:0] !== word[H_FIELD_W-1:0])
                tracker.flag("h_threshold read-back", word[H_FIELD_W-1:0], back[H_FIELD_W-1:0]);

            word = $urandom();
            word[V_FIELD_W-1:0] = v_set[s][V_FIELD_W-1:0];
            apb_write(REG_V_THR, word);
            tracker.load_threshold(REG_V_THR, word);
            apb_read(REG_V_THR, back);
            if (back[V_FIELD_W-1:0] !== word[V_FIELD_W-1:0])
                tracker.flag("v_threshold read-back", word[V_FIELD_W-1:0], back[V_FIELD_W-1:0]);

            if (s == 0) begin
                // directed opening: start-up with an empty history and both start
                // positions wrapping below zero, then a short sync tip
                foreach (corner[k]) begin
                    send_sample(corner[k]);
                    sent++;
                end
                repeat (12) begin
                    send_sample(-12'sd1024);
                    sent++;
                end
            end

            // Over all settings this fills the horizontal window many times over
            // and brings real data to the nearer vertical taps; the deepest taps
            // still read the zeroed start-up history.
            repeat (SAMPLES_PER_SETTING) begin
                send_sample(next_video_sample());
                sent++;
            end
            drain();
        end

        i_in_valid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        // pipeline is three deep; give stray results time to show
        repeat (10) @(posedge i_clk);

        $display("%0d samples through %0d threshold settings and three idling plans",
                 sent, SETTINGS_COUNT);
        $display("predicted %0d h_sync and %0d v_sync flags; %0d mismatches, %0d results owed",
                 tracker.h_flags, tracker.v_flags, tracker.faults, tracker.awaited.size());
        if (tracker.faults == 0 && tracker.awaited.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/vspd_pkg.sv
hdl/vspd_delay.sv
hdl/video_sync_pulse_detector.sv
verif/video_sync_pulse_detector_test.sv
